@@ src/nnis_pkg.sv @@
// Shared types and constants for the nearest-neighbor image scaler.
// Holds beat payload structs, controller/datapath command and status structs,
// register indexes and reset values. No dependencies.
package nnis_pkg;

   localparam int DEF_MAX_SRC_WIDTH    = 64;
   localparam int DEF_MAX_SRC_HEIGHT   = 64;
   localparam int DEF_FACTOR_FRAC_BITS = 8;

   localparam int DIM_W       = 7;
   localparam int FACTOR_W    = 10;
   localparam int TARGET_W    = 9;
   localparam int SCALED_W    = 9;
   localparam int POS_W       = 8;
   localparam int PIXEL_W     = 32;
   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_WIDTH     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_HEIGHT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_MODE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FACTOR  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_HEIGHT = 3'd5;

   localparam logic [DIM_W-1:0]    RST_SRC_WIDTH     = 7'd64;
   localparam logic [DIM_W-1:0]    RST_SRC_HEIGHT    = 7'd64;
   localparam logic                RST_FIT_MODE      = 1'b0;
   localparam logic [FACTOR_W-1:0] RST_SCALE_FACTOR  = 10'd256;
   localparam logic [TARGET_W-1:0] RST_TARGET_WIDTH  = 9'd64;
   localparam logic [TARGET_W-1:0] RST_TARGET_HEIGHT = 9'd64;

   localparam logic [FACTOR_W-1:0] FACTOR_MAX = 10'd1023;
   localparam logic [SCALED_W-1:0] SCALED_MAX = 9'd256;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [PIXEL_W-1:0] pixel_in;
   } req_item_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic [POS_W-1:0]   out_col;
      logic [POS_W-1:0]   out_row;
      logic               last_pixel;
      logic               status;
   } rsp_item_type;

   typedef struct packed {
      logic load_pixel;
      logic div_start;
      logic div_fit;
      logic set_factor;
      logic set_scale;
      logic calc_addr;
      logic read_mem;
      logic out_load;
      logic out_error;
   } nnis_cmd_type;

   typedef struct packed {
      logic req_fetch;
      logic load_complete;
      logic fit_mode;
      logic fetch_error;
      logic div_done;
      logic out_free;
   } nnis_status_type;

endpackage

@@ src/nnis_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Used by the scaler datapath; depends on nothing else.
module nnis_divider #(
   parameter int DVD_W = 17,
   parameter int DVS_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DVD_W-1:0]  quo_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  dvs_ff;

   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              fits;

   // Bring down the next dividend bit and try to subtract the divisor.
   always_comb begin
      trial = {rem_ff, quo_ff[DVD_W-1]};
      fits  = trial >= {1'b0, dvs_ff};
      diff  = trial - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(DVD_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
         rem_ff <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ src/nnis_datapath.sv @@
// Scaler datapath: configuration registers, frame store, counters, two dividers
// and the result register. Depends on nnis_pkg and nnis_divider.
module nnis_datapath #(
   parameter int MAX_SRC_WIDTH    = nnis_pkg::DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT   = nnis_pkg::DEF_MAX_SRC_HEIGHT,
   parameter int FACTOR_FRAC_BITS = nnis_pkg::DEF_FACTOR_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [nnis_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [nnis_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  nnis_pkg::req_item_type                req_data,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output nnis_pkg::rsp_item_type                rsp_data,
   input  nnis_pkg::nnis_cmd_type                cmd,
   output nnis_pkg::nnis_status_type             status
);

   import nnis_pkg::*;

   localparam int DEPTH   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int TOTAL_W = 2 * DIM_W;
   localparam int CMP_W   = (CW > TOTAL_W) ? CW : TOTAL_W;
   localparam int DVD_W   = TARGET_W + FACTOR_FRAC_BITS;
   localparam int DVS_W   = FACTOR_W;
   localparam int PROD_W  = FACTOR_W + DIM_W;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
      if (v == '0) return DIM_W'(1);
      if (int'(v) > maxv) return DIM_W'(maxv);
      return v;
   endfunction

   function automatic logic [DIM_W-1:0] sat_index(input logic [DVD_W-1:0] q,
                                                  input logic [DIM_W-1:0] n);
      if (q >= DVD_W'(n)) return n - 1'b1;
      return q[DIM_W-1:0];
   endfunction

   function automatic logic [SCALED_W-1:0] scaled_dim(input logic [FACTOR_W-1:0] f,
                                                      input logic [DIM_W-1:0] n);
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] s;
      prod = PROD_W'(f) * PROD_W'(n);
      s    = prod >> FACTOR_FRAC_BITS;
      if (s > PROD_W'(SCALED_MAX)) return SCALED_MAX;
      return s[SCALED_W-1:0];
   endfunction

   // Configuration registers.
   logic [DIM_W-1:0]    src_width_ff;
   logic [DIM_W-1:0]    src_height_ff;
   logic                fit_mode_ff;
   logic [FACTOR_W-1:0] scale_factor_ff;
   logic [TARGET_W-1:0] target_width_ff;
   logic [TARGET_W-1:0] target_height_ff;

   // Image and scan state.
   logic [CW-1:0]       load_count_ff;
   logic                loaded_ff;
   logic                done_ff;
   logic [DIM_W-1:0]    lat_w_ff;
   logic [DIM_W-1:0]    lat_h_ff;
   logic [FACTOR_W-1:0] factor_ff;
   logic [SCALED_W-1:0] scaled_w_ff;
   logic [SCALED_W-1:0] scaled_h_ff;
   logic [POS_W-1:0]    col_ff;
   logic [POS_W-1:0]    row_ff;
   logic [AW-1:0]       addr_ff;
   logic [PIXEL_W-1:0]  rd_data_ff;
   logic                rsp_valid_ff;
   rsp_item_type        rsp_data_ff;

   logic [PIXEL_W-1:0]  frame_store [DEPTH];

   logic [DIM_W-1:0]    cur_w;
   logic [DIM_W-1:0]    cur_h;
   logic [TOTAL_W-1:0]  total;
   logic                restart;
   logic [CW-1:0]       load_base;
   logic [CW-1:0]       load_next;

   logic [DVD_W-1:0]    dvd_col;
   logic [DVD_W-1:0]    dvd_row;
   logic [DVS_W-1:0]    dvs_col;
   logic [DVS_W-1:0]    dvs_row;
   logic [DVD_W-1:0]    quo_col;
   logic [DVD_W-1:0]    quo_row;
   logic                done_col;
   logic                done_row;

   logic [DVD_W-1:0]    quo_min;
   logic [FACTOR_W-1:0] fit_factor;
   logic [FACTOR_W-1:0] new_factor;
   logic [SCALED_W-1:0] new_scaled_w;
   logic [SCALED_W-1:0] new_scaled_h;
   logic [DIM_W-1:0]    src_col;
   logic [DIM_W-1:0]    src_row;
   logic [TOTAL_W-1:0]  addr_calc;
   logic                last_pos;
   logic                row_wrap;

   always_comb begin
      cur_w     = clamp_dim(src_width_ff, MAX_SRC_WIDTH);
      cur_h     = clamp_dim(src_height_ff, MAX_SRC_HEIGHT);
      total     = TOTAL_W'(cur_w) * TOTAL_W'(cur_h);
      // A new image starts after a finished one, or when the size shrank to or below the count.
      restart   = loaded_ff || (CMP_W'(load_count_ff) >= CMP_W'(total));
      load_base = restart ? '0 : load_count_ff;
      load_next = load_base + 1'b1;
   end

   // Both dividers run side by side: target box over source size in fit mode,
   // or output position over the factor when fetching.
   always_comb begin
      if (cmd.div_fit) begin
         dvd_col = DVD_W'(target_width_ff) << FACTOR_FRAC_BITS;
         dvd_row = DVD_W'(target_height_ff) << FACTOR_FRAC_BITS;
         dvs_col = DVS_W'(cur_w);
         dvs_row = DVS_W'(cur_h);
      end else begin
         dvd_col = DVD_W'(col_ff) << FACTOR_FRAC_BITS;
         dvd_row = DVD_W'(row_ff) << FACTOR_FRAC_BITS;
         dvs_col = factor_ff;
         dvs_row = factor_ff;
      end
   end

   nnis_divider #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_div_col (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd_col),
      .divisor  (dvs_col),
      .done     (done_col),
      .quotient (quo_col)
   );

   nnis_divider #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_div_row (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd_row),
      .divisor  (dvs_row),
      .done     (done_row),
      .quotient (quo_row)
   );

   always_comb begin
      quo_min = (quo_col < quo_row) ? quo_col : quo_row;
      if (quo_min == '0) begin
         fit_factor = FACTOR_W'(1);
      end else if (quo_min > DVD_W'(FACTOR_MAX)) begin
         fit_factor = FACTOR_MAX;
      end else begin
         fit_factor = quo_min[FACTOR_W-1:0];
      end
      if (fit_mode_ff) begin
         new_factor = fit_factor;
      end else begin
         new_factor = (scale_factor_ff == '0) ? FACTOR_W'(1) : scale_factor_ff;
      end
      new_scaled_w = scaled_dim(factor_ff, lat_w_ff);
      new_scaled_h = scaled_dim(factor_ff, lat_h_ff);
      src_col      = sat_index(quo_col, lat_w_ff);
      src_row      = sat_index(quo_row, lat_h_ff);
      addr_calc    = TOTAL_W'(src_row) * TOTAL_W'(lat_w_ff) + TOTAL_W'(src_col);
      row_wrap     = ({1'b0, row_ff} + 1'b1) == scaled_h_ff;
      last_pos     = row_wrap && (({1'b0, col_ff} + 1'b1) == scaled_w_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff     <= RST_SRC_WIDTH;
         src_height_ff    <= RST_SRC_HEIGHT;
         fit_mode_ff      <= RST_FIT_MODE;
         scale_factor_ff  <= RST_SCALE_FACTOR;
         target_width_ff  <= RST_TARGET_WIDTH;
         target_height_ff <= RST_TARGET_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:     src_width_ff     <= csr_wdata[DIM_W-1:0];
            CSR_SRC_HEIGHT:    src_height_ff    <= csr_wdata[DIM_W-1:0];
            CSR_FIT_MODE:      fit_mode_ff      <= csr_wdata[0];
            CSR_SCALE_FACTOR:  scale_factor_ff  <= csr_wdata[FACTOR_W-1:0];
            CSR_TARGET_WIDTH:  target_width_ff  <= csr_wdata[TARGET_W-1:0];
            CSR_TARGET_HEIGHT: target_height_ff <= csr_wdata[TARGET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         loaded_ff     <= 1'b0;
         done_ff       <= 1'b0;
         scaled_w_ff   <= '0;
         scaled_h_ff   <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load_pixel) begin
            load_count_ff <= load_next;
            if (restart) begin
               loaded_ff <= 1'b0;
               done_ff   <= 1'b0;
            end
         end
         if (cmd.set_scale) begin
            scaled_w_ff <= new_scaled_w;
            scaled_h_ff <= new_scaled_h;
            col_ff      <= '0;
            row_ff      <= '0;
            loaded_ff   <= 1'b1;
            done_ff     <= (new_scaled_w == '0) || (new_scaled_h == '0);
         end
         if (cmd.out_load && !cmd.out_error) begin
            if (last_pos) begin
               done_ff <= 1'b1;
            end else if (row_wrap) begin
               row_ff <= '0;
               col_ff <= col_ff + 1'b1;
            end else begin
               row_ff <= row_ff + 1'b1;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_pixel && (CMP_W'(load_next) == CMP_W'(total))) begin
         lat_w_ff <= cur_w;
         lat_h_ff <= cur_h;
      end
      if (cmd.set_factor) begin
         factor_ff <= new_factor;
      end
      if (cmd.calc_addr) begin
         addr_ff <= AW'(addr_calc);
      end
      if (cmd.out_load) begin
         if (cmd.out_error) begin
            rsp_data_ff <= '{pixel_out: '0, out_col: '0, out_row: '0,
                             last_pixel: 1'b0, status: STATUS_ERR};
         end else begin
            rsp_data_ff.pixel_out  <= rd_data_ff;
            rsp_data_ff.out_col    <= col_ff;
            rsp_data_ff.out_row    <= row_ff;
            rsp_data_ff.last_pixel <= last_pos;
            rsp_data_ff.status     <= STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         frame_store[AW'(load_base)] <= req_data.pixel_in;
      end
      if (cmd.read_mem) begin
         rd_data_ff <= frame_store[addr_ff];
      end
   end

   always_comb begin
      status.req_fetch     = req_data.req_type == REQ_FETCH;
      status.load_complete = CMP_W'(load_next) == CMP_W'(total);
      status.fit_mode      = fit_mode_ff;
      status.fetch_error   = !loaded_ff || done_ff;
      status.div_done      = done_col && done_row;
      status.out_free      = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/nnis_ctrl.sv @@
// Scaler controller: sequences loads, factor setup and pixel fetches.
// Drives the datapath by command struct; depends on nnis_pkg.
module nnis_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  nnis_pkg::nnis_status_type status,
   output nnis_pkg::nnis_cmd_type    cmd
);

   import nnis_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FDIV,
      S_FACTOR,
      S_SCALE,
      S_PDIV,
      S_ADDR,
      S_READ,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      err_ff;
   logic      err_in;

   always_comb begin
      state_in  = state_ff;
      err_in    = err_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.req_fetch) begin
                  if (status.fetch_error) begin
                     err_in   = 1'b1;
                     state_in = S_OUT;
                  end else begin
                     err_in        = 1'b0;
                     cmd.div_start = 1'b1;
                     state_in      = S_PDIV;
                  end
               end else begin
                  cmd.load_pixel = 1'b1;
                  if (status.load_complete) begin
                     if (status.fit_mode) begin
                        cmd.div_start = 1'b1;
                        cmd.div_fit   = 1'b1;
                        state_in      = S_FDIV;
                     end else begin
                        state_in = S_FACTOR;
                     end
                  end
               end
            end
         end
         S_FDIV: begin
            if (status.div_done) begin
               state_in = S_FACTOR;
            end
         end
         S_FACTOR: begin
            cmd.set_factor = 1'b1;
            state_in       = S_SCALE;
         end
         S_SCALE: begin
            cmd.set_scale = 1'b1;
            state_in      = S_IDLE;
         end
         S_PDIV: begin
            if (status.div_done) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            cmd.calc_addr = 1'b1;
            state_in      = S_READ;
         end
         S_READ: begin
            cmd.read_mem = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_error = err_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
   end

endmodule

@@ src/nearest_neighbor_image_scaler.sv @@
// Nearest-neighbor image scaler, top level.
// The beat that completes an image is followed by the factor setup (a division in
// fit mode) and the size setup. A fetch beat waits on the bit-serial dividers;
// an error fetch skips them. The result register frees the input side.
// Synchronous active-high reset clears control state; the frame store is not cleared.
module nearest_neighbor_image_scaler #(
   parameter int MAX_SRC_WIDTH    = nnis_pkg::DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT   = nnis_pkg::DEF_MAX_SRC_HEIGHT,
   parameter int FACTOR_FRAC_BITS = nnis_pkg::DEF_FACTOR_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  nnis_pkg::req_item_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output nnis_pkg::rsp_item_type           rsp_data,
   input  logic                             csr_we,
   input  logic [nnis_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nnis_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import nnis_pkg::*;

   // The controller only ever sees req_valid and the status flags; all pixel, counter and
   // geometry state lives in the datapath.
   nnis_cmd_type    cmd;
   nnis_status_type status;

   // Controller: idles with ready high, then walks one beat through its steps.
   // A load beat writes the frame store in the accept cycle. When it is the
   // final pixel of the image, the controller runs the factor setup (two
   // parallel divisions in fit mode), then latches the scaled size.
   // A fetch beat starts two parallel divisions (column and row over the
   // factor), forms the source address, reads the frame store and finally
   // writes the result register once it is free; an error fetch goes straight there.
   nnis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: configuration registers, frame store, scan counters, the two
   // dividers and the result register that holds a beat until it is taken.
   nnis_datapath #(
      .MAX_SRC_WIDTH    (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT   (MAX_SRC_HEIGHT),
      .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
